// ===== src/lpec_pkg.sv =====
// Shared types, constants and helper functions for the LED PWM effect controller.
package lpec_pkg;

  // Defaults for the top level parameters
  localparam int unsigned DefPeriod   = 400;
  localparam int unsigned DefChannels = 4;

  // Effect constants
  localparam int unsigned LevelFull = 255;
  localparam logic [15:0] GlowHigh  = 16'd395;
  localparam logic [15:0] GlowLow   = 16'd240;
  localparam int unsigned GlowDiv   = 5;

  localparam logic [15:0] BlinkIvlReset = 16'd500;

  // Width of the glow call phase, which runs from 0 to GlowDiv-1
  localparam int unsigned PhaseW = $clog2(GlowDiv);

  typedef enum logic [1:0] {
    OP_SET_LEVEL   = 2'd0,
    OP_TOGGLE      = 2'd1,
    OP_GLOW_STEP   = 2'd2,
    OP_BLINK_CHECK = 2'd3
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [1:0]  channel;
    logic [7:0]  level;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [15:0] compare_value;
    logic        write_strobe;
  } out_word_t;

  // Per-channel effect state
  typedef struct packed {
    logic [15:0]       cmp;
    logic              glow_up;
    logic [7:0]        glow_cnt;
    logic [PhaseW-1:0] glow_phase;
    logic [31:0]       last_blink;
  } chan_state_t;

  // Inverted duty for every brightness byte, built at elaboration
  function automatic logic [255:0][15:0] level_table(int unsigned period);
    logic [255:0][15:0] t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = 16'(period - (period * i) / LevelFull);
    end
    return t;
  endfunction

endpackage

// ===== src/lpec_in_if.sv =====
// Valid/ready channel carrying one command word into the controller.
interface lpec_in_if;
  logic               valid;
  logic               ready;
  lpec_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/lpec_out_if.sv =====
// Valid/ready channel carrying one result word out of the controller.
interface lpec_out_if;
  logic                valid;
  logic                ready;
  lpec_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/led_pwm_effect_controller_core.sv =====
// Top level of the LED PWM effect controller: handshake, channel state and registers.
//
//  Channel  Dir  Handshake         Word
//  -------  ---  ----------------  -------------------------------------------
//  in_i     in   valid / ready     operation, channel, level, now_ms
//  out_o    out  valid / ready     out_channel, compare_value, write_strobe
//  cfg      in   cfg_we_i only     blink_interval_ms (16 bits)
//
//  One word per cycle sustained while out_o is ready. A word waits in the
//  input register, the effect update runs between that register and the
//  result register, and the result register drives the result on out_o. The
//  channel state is read and written in the same cycle, so words for the
//  same channel may follow each other without bubbles. A stalled result
//  holds the input register; in_i stays ready while the result register
//  drains in the same cycle.
//  Reset puts every compare value at PERIOD, glow down, counts and blink
//  times at zero and the blink interval at 500 ms.
module led_pwm_effect_controller_core #(
  parameter int unsigned PERIOD   = lpec_pkg::DefPeriod,
  parameter int unsigned CHANNELS = lpec_pkg::DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpec_in_if.sink     in_i,
  lpec_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam logic [15:0] PeriodW = 16'(PERIOD);
  localparam logic [2:0]  ChanLim = 3'(CHANNELS);

  // handshake
  logic s1_vld_q, s1_vld_d;
  logic out_vld_q, out_vld_d;
  logic out_free, s1_adv, in_acc;

  // payload
  lpec_pkg::in_word_t  s1_q;
  lpec_pkg::out_word_t out_q, out_d;

  // configuration
  logic [15:0] blink_ivl_q;

  // channel state
  lpec_pkg::chan_state_t st_q [CHANNELS];
  lpec_pkg::chan_state_t rd_st, wr_st;
  lpec_pkg::out_word_t   res;
  logic                  ch_ok, upd;

  assign out_free = !out_vld_q || out_o.ready;
  assign s1_adv   = s1_vld_q && out_free;
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_acc   = in_i.valid && in_i.ready;

  assign s1_vld_d  = in_acc || (s1_vld_q && !s1_adv);
  assign out_vld_d = s1_adv || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_i.data;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ivl_q <= lpec_pkg::BlinkIvlReset;
    end else if (cfg_we_i) begin
      blink_ivl_q <= cfg_wdata_i;
    end
  end

  // channels at or beyond CHANNELS are ignored and report zero
  assign ch_ok = {1'b0, s1_q.channel} < ChanLim;
  assign upd   = s1_adv && ch_ok;

  always_comb begin
    rd_st = '0;
    for (int unsigned i = 0; i < CHANNELS; i++) begin
      if (s1_q.channel == 2'(i)) begin
        rd_st = st_q[i];
      end
    end
  end

  lpec_op_unit #(
    .PERIOD (PERIOD)
  ) u_op (
    .cmd_i       (s1_q),
    .state_i     (rd_st),
    .blink_ivl_i (blink_ivl_q),
    .state_o     (wr_st),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CHANNELS; i++) begin
        st_q[i].cmp        <= PeriodW;
        st_q[i].glow_up    <= 1'b0;
        st_q[i].glow_cnt   <= '0;
        st_q[i].glow_phase <= '0;
        st_q[i].last_blink <= '0;
      end
    end else begin
      for (int unsigned i = 0; i < CHANNELS; i++) begin
        if (upd && s1_q.channel == 2'(i)) begin
          st_q[i] <= wr_st;
        end
      end
    end
  end

  always_comb begin
    if (ch_ok) begin
      out_d = res;
    end else begin
      out_d               = '0;
      out_d.out_channel   = s1_q.channel;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // strobe never fires for a value past the period
  a_strobe_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.write_strobe |-> out_q.compare_value <= PeriodW)
    else $error("write strobe with compare value beyond PERIOD");

  // ignored channels report a zero word
  a_bad_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !ch_ok |=> out_vld_q && out_q.compare_value == '0 && !out_q.write_strobe)
    else $error("result for absent channel is not zero");

  // a word leaving the input register lands in the result register
  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("advanced word lost");

  // glow phase stays within the divider
  a_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |-> rd_st.glow_phase <= lpec_pkg::PhaseW'(lpec_pkg::GlowDiv - 1))
    else $error("glow phase out of range");

endmodule

// ===== src/lpec_op_unit.sv =====
// Combinational effect update: one command word against one channel's state.
module lpec_op_unit #(
  parameter int unsigned PERIOD = lpec_pkg::DefPeriod
) (
  input  lpec_pkg::in_word_t    cmd_i,
  input  lpec_pkg::chan_state_t state_i,
  input  logic [15:0]           blink_ivl_i,
  output lpec_pkg::chan_state_t state_o,
  output lpec_pkg::out_word_t   result_o
);

  localparam logic [15:0] PeriodW   = 16'(PERIOD);
  localparam logic [15:0] ToggleLow = 16'((3 * PERIOD) / 4);
  localparam logic [255:0][15:0] LevelTable = lpec_pkg::level_table(PERIOD);
  localparam logic [lpec_pkg::PhaseW-1:0] PhaseLast =
    lpec_pkg::PhaseW'(lpec_pkg::GlowDiv - 1);

  logic [15:0] toggled;
  logic [31:0] elapsed;
  logic        dir_up;
  logic [15:0] nv;
  logic        wr;

  assign toggled = (state_i.cmp <= ToggleLow) ? PeriodW : ToggleLow;
  assign elapsed = cmd_i.now_ms - state_i.last_blink;

  // direction after the turn-round check at the ends of the glow range
  always_comb begin
    priority if (state_i.cmp >= lpec_pkg::GlowHigh) begin
      dir_up = 1'b0;
    end else if (state_i.cmp <= lpec_pkg::GlowLow) begin
      dir_up = 1'b1;
    end else begin
      dir_up = state_i.glow_up;
    end
  end

  always_comb begin
    state_o = state_i;
    nv      = state_i.cmp;
    wr      = 1'b0;
    unique case (cmd_i.operation)
      lpec_pkg::OP_SET_LEVEL: begin
        nv = LevelTable[cmd_i.level];
        wr = 1'b1;
      end
      lpec_pkg::OP_TOGGLE: begin
        nv = toggled;
        wr = 1'b1;
      end
      lpec_pkg::OP_GLOW_STEP: begin
        // step only on every fifth call; the 8-bit count wrap restarts the phase
        if (state_i.glow_phase == '0) begin
          state_o.glow_up = dir_up;
          nv = dir_up ? state_i.cmp + 16'd1 : state_i.cmp - 16'd1;
          wr = 1'b1;
        end
        state_o.glow_cnt = state_i.glow_cnt + 8'd1;
        if (state_i.glow_cnt == 8'hFF || state_i.glow_phase == PhaseLast) begin
          state_o.glow_phase = '0;
        end else begin
          state_o.glow_phase = state_i.glow_phase + 1'b1;
        end
      end
      lpec_pkg::OP_BLINK_CHECK: begin
        if (elapsed >= {16'd0, blink_ivl_i}) begin
          state_o.last_blink = cmd_i.now_ms;
          nv = toggled;
          wr = 1'b1;
        end
      end
      default: begin
        nv = state_i.cmp;
      end
    endcase
    state_o.cmp = nv;
  end

  assign result_o.out_channel   = cmd_i.channel;
  assign result_o.compare_value = nv;
  assign result_o.write_strobe  = wr && (nv <= PeriodW);

endmodule
